>>> src/dcpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpr_pkg
// Shared constants, codes and types of the delay calibration phase rotator.
// ----------------------------------------------------------------------------
package dcpr_pkg;

    localparam int DEF_MAX_SLOTS      = 64;
    localparam int DEF_MAX_ANTENNAS   = 16;
    localparam int DEF_MAX_BANDS      = 16;
    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_PHASE_LUT_BITS = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] OP_LOAD_TIME  = 2'd0;
    localparam logic [1:0] OP_LOAD_DELAY = 2'd1;
    localparam logic [1:0] OP_CORRECT    = 2'd2;
    localparam logic [1:0] OP_NONE       = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POL_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_POL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_SPACING = 3'd3;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [1:0] {
        KIND_TIME,
        KIND_DELAY,
        KIND_CORRECT,
        KIND_PASS
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  slot;
        logic [3:0]  ant_a;
        logic [3:0]  ant_b;
        logic [5:0]  band_a;
        logic [5:0]  band_b;
        logic        ok_a;
        logic        ok_b;
        logic [47:0] time_stamp;
        logic [31:0] delay_value;
        logic [15:0] channel;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  slot_count;
        logic [1:0]  pol_count;
        logic [7:0]  first_pol_code;
        logic [31:0] chan_spacing;
    } cfg_t;

endpackage

>>> src/dcpr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpr_front
// Accepts input items, forms band indexes and range checks, and sorts each
// item into a command for the back end. Items with nothing to do are dropped.
// ----------------------------------------------------------------------------
module dcpr_front
    import dcpr_pkg::*;
#(
    parameter int MAX_SLOTS    = DEF_MAX_SLOTS,
    parameter int MAX_ANTENNAS = DEF_MAX_ANTENNAS,
    parameter int MAX_BANDS    = DEF_MAX_BANDS
)
(
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [5:0]  slot,
    input  logic [3:0]  antenna_a,
    input  logic [3:0]  antenna_b,
    input  logic [7:0]  pol_a,
    input  logic [7:0]  pol_b,
    input  logic [3:0]  freq_index,
    input  logic [47:0] time_stamp,
    input  logic [31:0] delay_value,
    input  logic [15:0] channel,
    input  cfg_t        cfg,
    input  logic        q_full,
    output logic        push,
    output cmd_t        cmd
);

    logic [1:0] pc;
    logic       keep;
    logic       slot_ok;

    function automatic logic [5:0] band_of(input logic [3:0] f, input logic [1:0] p,
                                           input logic [7:0] pol, input logic [7:0] first);
        logic [5:0] base;
        base = (p == 2'd2) ? {1'b0, f, 1'b0} : {2'b00, f};
        return base + {5'd0, (pol != first)};
    endfunction

    always_comb
    begin
        if (cfg.pol_count == 2'd0)
            pc = 2'd1;
        else if (cfg.pol_count == 2'd3)
            pc = 2'd2;
        else
            pc = cfg.pol_count;

        cmd.slot        = slot;
        cmd.ant_a       = antenna_a;
        cmd.ant_b       = antenna_b;
        cmd.band_a      = band_of(freq_index, pc, pol_a, cfg.first_pol_code);
        cmd.band_b      = band_of(freq_index, pc, pol_b, cfg.first_pol_code);
        cmd.ok_a        = (32'(antenna_a) < 32'(MAX_ANTENNAS)) &&
                          (32'(cmd.band_a) < 32'(MAX_BANDS));
        cmd.ok_b        = (32'(antenna_b) < 32'(MAX_ANTENNAS)) &&
                          (32'(cmd.band_b) < 32'(MAX_BANDS));
        cmd.time_stamp  = time_stamp;
        cmd.delay_value = delay_value;
        cmd.channel     = channel;
        slot_ok         = 32'(slot) < 32'(MAX_SLOTS);

        case (operation)
            OP_LOAD_TIME:
            begin
                cmd.kind = KIND_TIME;
                keep     = slot_ok;
            end
            OP_LOAD_DELAY:
            begin
                cmd.kind = KIND_DELAY;
                keep     = slot_ok && cmd.ok_a;
            end
            OP_CORRECT:
            begin
                cmd.kind = (antenna_a == antenna_b && pol_a == pol_b) ? KIND_PASS
                                                                      : KIND_CORRECT;
                keep     = 1'b1;
            end
            default:
            begin
                cmd.kind = KIND_TIME;
                keep     = 1'b0;
            end
        endcase
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full && keep;

endmodule

>>> src/dcpr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpr_fifo
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module dcpr_fifo
    import dcpr_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign rdata = mem_reg[rd_ptr_reg];
    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                mem_reg[wr_ptr_reg] <= wdata;
                wr_ptr_reg          <= !wr_ptr_reg;
            end
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

>>> src/dcpr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpr_back
// Executes commands: table loads, slot search and weight division, delay
// interpolation, phase computation and sample rotation with rounding.
// ----------------------------------------------------------------------------
module dcpr_back
    import dcpr_pkg::*;
#(
    parameter int MAX_SLOTS      = DEF_MAX_SLOTS,
    parameter int MAX_ANTENNAS   = DEF_MAX_ANTENNAS,
    parameter int MAX_BANDS      = DEF_MAX_BANDS,
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int PHASE_LUT_BITS = DEF_PHASE_LUT_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          q_empty,
    input  cmd_t                          q_cmd,
    input  logic signed [SAMPLE_BITS-1:0] q_re,
    input  logic signed [SAMPLE_BITS-1:0] q_im,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_re,
    output logic signed [SAMPLE_BITS-1:0] out_im,
    output logic                          passed_through
);

    localparam int SB       = SAMPLE_BITS;
    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int DLY_AW   = $clog2(MAX_SLOTS * MAX_ANTENNAS * MAX_BANDS);
    localparam int DLY_N    = MAX_SLOTS * MAX_ANTENNAS * MAX_BANDS;
    localparam int LUT_SIZE = 1 << PHASE_LUT_BITS;
    localparam int QUARTER  = LUT_SIZE / 4;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK_FIRST, S_CHK_LAST, S_CHK_LO, S_WALK, S_T0, S_DIV,
        S_DLY, S_PH, S_LUT, S_ROT0, S_ROT1, S_ROT2, S_DONE
    } state_t;

    function automatic logic [QUARTER*34-1:0] build_qtab();
        logic [QUARTER*34-1:0] tab;
        longint unsigned       x;
        longint unsigned       x2;
        longint unsigned       ts;
        longint unsigned       tc;
        longint                ss;
        longint                cs;
        logic [16:0]           cq;
        logic [16:0]           sq;
        tab = '0;
        for (int j = 0; j < QUARTER; j++)
        begin
            if (j == 0)
            begin
                cq = ONE_Q16;
                sq = 17'd0;
            end
            else
            begin
                x  = (TWO_PI_Q30 * 64'(j) + 64'(LUT_SIZE / 2)) >> PHASE_LUT_BITS;
                x2 = (x * x) >> 30;
                ts = x;
                ss = longint'(x);
                tc = 64'd1 << 30;
                cs = longint'(tc);
                for (int n = 1; n <= 8; n++)
                begin
                    ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                    tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                    if ((n % 2) == 1)
                    begin
                        ss = ss - longint'(ts);
                        cs = cs - longint'(tc);
                    end
                    else
                    begin
                        ss = ss + longint'(ts);
                        cs = cs + longint'(tc);
                    end
                end
                if (cs < 0)
                    cs = 0;
                if (ss < 0)
                    ss = 0;
                cq = 17'((cs + 8192) >>> 14);
                sq = 17'((ss + 8192) >>> 14);
            end
            tab[j*34 +: 34] = {cq, sq};
        end
        return tab;
    endfunction

    localparam logic [QUARTER*34-1:0] QTAB = build_qtab();

    function automatic logic [DLY_AW-1:0] dly_addr(input logic [31:0] s,
                                                    input logic [3:0] a,
                                                    input logic [5:0] b);
        logic [31:0] full;
        full = (s * 32'(MAX_ANTENNAS) + 32'(a)) * 32'(MAX_BANDS) + 32'(b);
        return full[DLY_AW-1:0];
    endfunction

    function automatic logic signed [SB-1:0] rnd_sat(input logic signed [SB+18:0] v);
        logic signed [SB+18:0] r;
        logic [3:0]            top;
        logic signed [SB-1:0]  res;
        r   = v + (SB+19)'(32768);
        top = r[SB+18 -: 4];
        if (top == 4'b0000 || top == 4'b1111)
            res = r[SB+15:16];
        else if (top[3])
            res = {1'b1, {(SB-1){1'b0}}};
        else
            res = {1'b0, {(SB-1){1'b1}}};
        return res;
    endfunction

    logic [47:0] slot_mem [MAX_SLOTS];
    logic [31:0] dly_mem [DLY_N];
    logic [47:0] slot_rdata_reg;
    logic [31:0] dly_rdata_reg;

    state_t                 state_reg;
    cmd_t                   item_reg;
    logic signed [SB-1:0]   re_reg;
    logic signed [SB-1:0]   im_reg;
    logic [47:0]            cached_time_reg;
    logic [47:0]            t1_reg;
    logic [47:0]            den_reg;
    logic [48:0]            rem_reg;
    logic [16:0]            q_reg;
    logic [4:0]             div_cnt_reg;
    logic [SLOT_W-1:0]      lower_reg;
    logic [SLOT_W-1:0]      upper_reg;
    logic [SLOT_W-1:0]      up_reg;
    logic [16:0]            wl_reg;
    logic [16:0]            wu_reg;
    logic [2:0]             step_reg;
    logic signed [49:0]     prod_reg;
    logic                   prod_neg_reg;
    logic signed [51:0]     diff_reg;
    logic [47:0]            cs_prod_reg;
    logic [51:0]            pp_reg;
    logic [1:0]             pp_sel_reg;
    logic [55:0]            phase_reg;
    logic signed [17:0]     cos_reg;
    logic signed [17:0]     sin_reg;
    logic signed [SB+17:0]  m1_reg;
    logic signed [SB+17:0]  m2_reg;
    logic signed [SB+18:0]  sum_re_reg;
    logic                   out_valid_reg;
    logic signed [SB-1:0]   out_re_reg;
    logic signed [SB-1:0]   out_im_reg;
    logic                   pass_reg;

    logic                   out_free;
    logic                   out_load;
    logic [SLOT_W-1:0]      n_m1;
    logic [SLOT_W-1:0]      up_sel;
    logic [SLOT_W-1:0]      up_clamp;
    logic                   walk_more;
    logic                   slot_we;
    logic [SLOT_W-1:0]      slot_waddr;
    logic [SLOT_W-1:0]      slot_raddr;
    logic                   dly_we;
    logic [DLY_AW-1:0]      dly_waddr;
    logic [DLY_AW-1:0]      dly_raddr;
    logic                   div_ge;
    logic [48:0]            div_r1;
    logic [16:0]            q_next;
    logic [1:0]             mul_idx;
    logic signed [49:0]     prod_next;
    logic [55:0]            d56;
    logic [23:0]            pp_a;
    logic [27:0]            pp_b;
    logic [55:0]            pp_shifted;
    logic [55:0]            phase_rnd;
    logic [PHASE_LUT_BITS-1:0] k_idx;
    logic [33:0]            qentry;
    logic signed [17:0]     qc;
    logic signed [17:0]     qs;
    logic signed [17:0]     cos_next;
    logic signed [17:0]     sin_next;
    logic signed [SB+18:0]  sum_im;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == S_IDLE) && !q_empty &&
                      (q_cmd.kind != KIND_PASS || out_free);
    assign out_load = ((state_reg == S_IDLE) && pop && q_cmd.kind == KIND_PASS) ||
                      ((state_reg == S_DONE) && out_free);

    always_comb
    begin
        if (cfg.slot_count == 7'd0)
            n_m1 = '0;
        else if (32'(cfg.slot_count) > 32'(MAX_SLOTS))
            n_m1 = SLOT_W'(MAX_SLOTS - 1);
        else
            n_m1 = SLOT_W'(cfg.slot_count - 7'd1);

        up_sel = (item_reg.time_stamp < slot_rdata_reg) ? SLOT_W'(1) : upper_reg;
        if (up_sel == '0)
            up_clamp = SLOT_W'(1);
        else if (up_sel > n_m1)
            up_clamp = n_m1;
        else
            up_clamp = up_sel;
        walk_more = (up_reg < n_m1) && (item_reg.time_stamp > slot_rdata_reg);

        case (state_reg)
            S_CHK_FIRST: slot_raddr = n_m1;
            S_CHK_LAST:  slot_raddr = lower_reg;
            S_CHK_LO:    slot_raddr = up_clamp;
            S_WALK:      slot_raddr = walk_more ? up_reg + SLOT_W'(1) : up_reg - SLOT_W'(1);
            default:     slot_raddr = '0;
        endcase

        slot_we    = pop && q_cmd.kind == KIND_TIME;
        slot_waddr = SLOT_W'(32'(q_cmd.slot));
        dly_we     = pop && q_cmd.kind == KIND_DELAY;
        dly_waddr  = dly_addr(32'(q_cmd.slot), q_cmd.ant_a, q_cmd.band_a);
        dly_raddr  = dly_addr(32'(step_reg[0] ? upper_reg : lower_reg),
                              step_reg[1] ? item_reg.ant_b : item_reg.ant_a,
                              step_reg[1] ? item_reg.band_b : item_reg.band_a);

        div_ge = rem_reg >= {1'b0, den_reg};
        div_r1 = div_ge ? rem_reg - {1'b0, den_reg} : rem_reg;
        q_next = {q_reg[15:0], div_ge};

        mul_idx   = 2'(step_reg - 3'd1);
        prod_next = (mul_idx[1] ? item_reg.ok_b : item_reg.ok_a)
                  ? $signed(dly_rdata_reg) * $signed({1'b0, mul_idx[0] ? wu_reg : wl_reg})
                  : 50'sd0;

        d56  = 56'(diff_reg);
        pp_a = step_reg[0] ? cs_prod_reg[47:24] : cs_prod_reg[23:0];
        pp_b = step_reg[1] ? d56[55:28] : d56[27:0];
        case (pp_sel_reg)
            2'd0:    pp_shifted = 56'(pp_reg);
            2'd1:    pp_shifted = 56'(pp_reg) << 24;
            2'd2:    pp_shifted = 56'(pp_reg) << 28;
            default: pp_shifted = 56'(pp_reg) << 52;
        endcase

        phase_rnd = phase_reg + (56'd1 << (55 - PHASE_LUT_BITS));
        k_idx     = phase_rnd[55 -: PHASE_LUT_BITS];
        qentry    = QTAB[32'(k_idx[PHASE_LUT_BITS-3:0]) * 34 +: 34];
        qc        = $signed({1'b0, qentry[33:17]});
        qs        = $signed({1'b0, qentry[16:0]});
        case (k_idx[PHASE_LUT_BITS-1 -: 2])
            2'd0:
            begin
                cos_next = qc;
                sin_next = qs;
            end
            2'd1:
            begin
                cos_next = -qs;
                sin_next = qc;
            end
            2'd2:
            begin
                cos_next = -qc;
                sin_next = -qs;
            end
            default:
            begin
                cos_next = qs;
                sin_next = -qc;
            end
        endcase

        sum_im = (SB+19)'(m1_reg) + (SB+19)'(m2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= q_cmd.time_stamp;
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dly_we)
            dly_mem[dly_waddr] <= q_cmd.delay_value;
        dly_rdata_reg <= dly_mem[dly_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            item_reg        <= '0;
            re_reg          <= '0;
            im_reg          <= '0;
            cached_time_reg <= '0;
            t1_reg          <= '0;
            den_reg         <= '0;
            rem_reg         <= '0;
            q_reg           <= '0;
            div_cnt_reg     <= '0;
            lower_reg       <= '0;
            upper_reg       <= '0;
            up_reg          <= '0;
            wl_reg          <= '0;
            wu_reg          <= '0;
            step_reg        <= '0;
            prod_reg        <= '0;
            prod_neg_reg    <= 1'b0;
            diff_reg        <= '0;
            cs_prod_reg     <= '0;
            pp_reg          <= '0;
            pp_sel_reg      <= '0;
            phase_reg       <= '0;
            cos_reg         <= '0;
            sin_reg         <= '0;
            m1_reg          <= '0;
            m2_reg          <= '0;
            sum_re_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_re_reg      <= '0;
            out_im_reg      <= '0;
            pass_reg        <= 1'b0;
        end
        else
        begin
            if (!out_stall && !out_load)
                out_valid_reg <= 1'b0;
            if (state_reg != S_DLY && state_reg != S_PH)
                step_reg <= '0;

            case (state_reg)
                S_IDLE:
                begin
                    if (pop && q_cmd.kind == KIND_PASS)
                    begin
                        out_valid_reg <= 1'b1;
                        out_re_reg    <= q_re;
                        out_im_reg    <= q_im;
                        pass_reg      <= 1'b1;
                    end
                    else if (pop && q_cmd.kind == KIND_CORRECT)
                    begin
                        item_reg <= q_cmd;
                        re_reg   <= q_re;
                        im_reg   <= q_im;
                        if (q_cmd.time_stamp != cached_time_reg)
                        begin
                            cached_time_reg <= q_cmd.time_stamp;
                            state_reg       <= S_CHK_FIRST;
                        end
                        else
                            state_reg <= S_DLY;
                    end
                end
                S_CHK_FIRST:
                begin
                    if (item_reg.time_stamp <= slot_rdata_reg)
                    begin
                        lower_reg <= '0;
                        upper_reg <= '0;
                        wl_reg    <= ONE_Q16;
                        wu_reg    <= '0;
                        state_reg <= S_DLY;
                    end
                    else
                        state_reg <= S_CHK_LAST;
                end
                S_CHK_LAST:
                begin
                    if (item_reg.time_stamp >= slot_rdata_reg)
                    begin
                        lower_reg <= n_m1;
                        upper_reg <= n_m1;
                        wl_reg    <= '0;
                        wu_reg    <= ONE_Q16;
                        state_reg <= S_DLY;
                    end
                    else
                        state_reg <= S_CHK_LO;
                end
                S_CHK_LO:
                begin
                    up_reg    <= up_clamp;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (walk_more)
                        up_reg <= up_reg + SLOT_W'(1);
                    else
                    begin
                        lower_reg <= up_reg - SLOT_W'(1);
                        upper_reg <= up_reg;
                        t1_reg    <= slot_rdata_reg;
                        state_reg <= S_T0;
                    end
                end
                S_T0:
                begin
                    if (t1_reg <= slot_rdata_reg)
                    begin
                        wl_reg    <= ONE_Q16;
                        wu_reg    <= '0;
                        state_reg <= S_DLY;
                    end
                    else
                    begin
                        den_reg <= t1_reg - slot_rdata_reg;
                        if (item_reg.time_stamp <= slot_rdata_reg)
                            rem_reg <= '0;
                        else if (item_reg.time_stamp - slot_rdata_reg > t1_reg - slot_rdata_reg)
                            rem_reg <= {1'b0, t1_reg - slot_rdata_reg};
                        else
                            rem_reg <= {1'b0, item_reg.time_stamp - slot_rdata_reg};
                        q_reg       <= '0;
                        div_cnt_reg <= 5'd16;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    q_reg   <= q_next;
                    rem_reg <= {div_r1[47:0], 1'b0};
                    if (div_cnt_reg == 5'd0)
                    begin
                        wu_reg    <= q_next;
                        wl_reg    <= ONE_Q16 - q_next;
                        state_reg <= S_DLY;
                    end
                    else
                        div_cnt_reg <= div_cnt_reg - 5'd1;
                end
                S_DLY:
                begin
                    if (step_reg == 3'd0)
                    begin
                        diff_reg    <= '0;
                        cs_prod_reg <= item_reg.channel * cfg.chan_spacing;
                    end
                    if (step_reg >= 3'd1 && step_reg <= 3'd4)
                    begin
                        prod_reg     <= prod_next;
                        prod_neg_reg <= !mul_idx[1];
                    end
                    if (step_reg >= 3'd2)
                        diff_reg <= prod_neg_reg ? diff_reg - 52'(prod_reg)
                                                 : diff_reg + 52'(prod_reg);
                    if (step_reg == 3'd5)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_PH;
                    end
                    else
                        step_reg <= step_reg + 3'd1;
                end
                S_PH:
                begin
                    if (step_reg == 3'd0)
                        phase_reg <= '0;
                    else
                        phase_reg <= phase_reg + pp_shifted;
                    pp_reg     <= pp_a * pp_b;
                    pp_sel_reg <= step_reg[1:0];
                    if (step_reg == 3'd4)
                        state_reg <= S_LUT;
                    else
                        step_reg <= step_reg + 3'd1;
                end
                S_LUT:
                begin
                    cos_reg   <= cos_next;
                    sin_reg   <= sin_next;
                    state_reg <= S_ROT0;
                end
                S_ROT0:
                begin
                    m1_reg    <= re_reg * cos_reg;
                    m2_reg    <= im_reg * sin_reg;
                    state_reg <= S_ROT1;
                end
                S_ROT1:
                begin
                    sum_re_reg <= (SB+19)'(m1_reg) - (SB+19)'(m2_reg);
                    m1_reg     <= re_reg * sin_reg;
                    m2_reg     <= im_reg * cos_reg;
                    state_reg  <= S_ROT2;
                end
                S_ROT2:
                begin
                    m1_reg    <= sum_im[SB+17:0];
                    m2_reg    <= '0;
                    sum_re_reg <= sum_re_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_re_reg    <= rnd_sat(sum_re_reg);
                        out_im_reg    <= rnd_sat(sum_im);
                        pass_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_re         = out_re_reg;
    assign out_im         = out_im_reg;
    assign passed_through = pass_reg;

endmodule

>>> src/delay_cal_phase_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delay_cal_phase_rotator
// Load items fill a slot time table and a delay table; a correct item carries
// one complex channel sample of a baseline, which is rotated by the phase of
// the interpolated delay difference of its two antennas. A load writes its
// table when it leaves the queue, and a sample with the same antenna and
// polarization on both sides passes through. A correction at the cached time
// reads the single delay table port four times, sums the partial products of
// the phase multiply and rotates the sample in states S_ROT0 to S_ROT2. When
// the time changes, a search over the slot times comes first, and the
// 17-step weight division follows. Configuration is written through a port
// that is always ready.
// ----------------------------------------------------------------------------
module delay_cal_phase_rotator
    import dcpr_pkg::*;
#(
    parameter int MAX_SLOTS      = DEF_MAX_SLOTS,
    parameter int MAX_ANTENNAS   = DEF_MAX_ANTENNAS,
    parameter int MAX_BANDS      = DEF_MAX_BANDS,
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int PHASE_LUT_BITS = DEF_PHASE_LUT_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic [5:0]                    slot,
    input  logic [3:0]                    antenna_a,
    input  logic [3:0]                    antenna_b,
    input  logic [7:0]                    pol_a,
    input  logic [7:0]                    pol_b,
    input  logic [3:0]                    freq_index,
    input  logic [47:0]                   time_stamp,
    input  logic signed [31:0]            delay_value,
    input  logic [15:0]                   channel,
    input  logic signed [SAMPLE_BITS-1:0] sample_re,
    input  logic signed [SAMPLE_BITS-1:0] sample_im,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_re,
    output logic signed [SAMPLE_BITS-1:0] out_im,
    output logic                          passed_through
);

    localparam int CMD_W = $bits(cmd_t);
    localparam int Q_W   = CMD_W + 2 * SAMPLE_BITS;

    cfg_t             cfg_reg;
    cmd_t             f_cmd;
    logic             f_push;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [Q_W-1:0]   q_rdata;
    cmd_t             q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_count     <= 7'd1;
            cfg_reg.pol_count      <= 2'd2;
            cfg_reg.first_pol_code <= 8'd82;
            cfg_reg.chan_spacing   <= 32'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SLOT_COUNT:   cfg_reg.slot_count     <= cfg_data[6:0];
                REG_POL_COUNT:    cfg_reg.pol_count      <= cfg_data[1:0];
                REG_FIRST_POL:    cfg_reg.first_pol_code <= cfg_data[7:0];
                REG_CHAN_SPACING: cfg_reg.chan_spacing   <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    dcpr_front #(
        .MAX_SLOTS    (MAX_SLOTS),
        .MAX_ANTENNAS (MAX_ANTENNAS),
        .MAX_BANDS    (MAX_BANDS)
    ) u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .slot        (slot),
        .antenna_a   (antenna_a),
        .antenna_b   (antenna_b),
        .pol_a       (pol_a),
        .pol_b       (pol_b),
        .freq_index  (freq_index),
        .time_stamp  (time_stamp),
        .delay_value (delay_value),
        .channel     (channel),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .push        (f_push),
        .cmd         (f_cmd)
    );

    dcpr_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata ({f_cmd, sample_re, sample_im}),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign q_cmd = q_rdata[Q_W-1 -: CMD_W];

    dcpr_back #(
        .MAX_SLOTS      (MAX_SLOTS),
        .MAX_ANTENNAS   (MAX_ANTENNAS),
        .MAX_BANDS      (MAX_BANDS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .PHASE_LUT_BITS (PHASE_LUT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .q_cmd          (q_cmd),
        .q_re           ($signed(q_rdata[2*SAMPLE_BITS-1 -: SAMPLE_BITS])),
        .q_im           ($signed(q_rdata[SAMPLE_BITS-1:0])),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_re         (out_re),
        .out_im         (out_im),
        .passed_through (passed_through)
    );

endmodule

>>> tb/tb_delay_cal_phase_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delay_cal_phase_rotator
// Self-checking bench for the delay calibration phase rotator. It loads the
// slot time and delay tables, then streams load, pass-through and correction
// items under several register settings with random gaps and stalls on both
// sides. A built-in predictor of the interpolation and rotation works out
// each expected sample, and every output item is compared with it in order.
// ----------------------------------------------------------------------------
module tb_delay_cal_phase_rotator;
    import dcpr_pkg::*;

    localparam int  LIMIT_CYCLES = 3000000;
    localparam int  SETTLE       = 200;
    localparam int  NSLOT        = DEF_MAX_SLOTS;
    localparam int  NANT         = DEF_MAX_ANTENNAS;
    localparam int  NBAND        = DEF_MAX_BANDS;
    localparam int  LUT_N        = 1 << DEF_PHASE_LUT_BITS;
    localparam int  QTR          = LUT_N / 4;

    typedef struct {
        logic [1:0]         op;
        logic [5:0]         slot;
        logic [3:0]         ant_a;
        logic [3:0]         ant_b;
        logic [7:0]         pol_a;
        logic [7:0]         pol_b;
        logic [3:0]         freq;
        logic [47:0]        tstamp;
        logic signed [31:0] delay;
        logic [15:0]        chan;
        logic signed [15:0] re;
        logic signed [15:0] im;
    } item_t;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               pass;
    } rot_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              operation;
    logic [5:0]              slot;
    logic [3:0]              antenna_a;
    logic [3:0]              antenna_b;
    logic [7:0]              pol_a;
    logic [7:0]              pol_b;
    logic [3:0]              freq_index;
    logic [47:0]             time_stamp;
    logic signed [31:0]      delay_value;
    logic [15:0]             channel;
    logic signed [15:0]      sample_re;
    logic signed [15:0]      sample_im;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [15:0]      out_re;
    logic signed [15:0]      out_im;
    logic                    passed_through;

    delay_cal_phase_rotator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .slot           (slot),
        .antenna_a      (antenna_a),
        .antenna_b      (antenna_b),
        .pol_a          (pol_a),
        .pol_b          (pol_b),
        .freq_index     (freq_index),
        .time_stamp     (time_stamp),
        .delay_value    (delay_value),
        .channel        (channel),
        .sample_re      (sample_re),
        .sample_im      (sample_im),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_re         (out_re),
        .out_im         (out_im),
        .passed_through (passed_through)
    );

    // Predictor state.
    logic [47:0]   slot_t [NSLOT];
    int            delay_tab [NSLOT*NANT*NBAND];
    int            cos_t [LUT_N];
    int            sin_t [LUT_N];
    logic [47:0]   cached_t;
    int unsigned   lo_slot;
    int unsigned   up_slot;
    int unsigned   lo_w;
    int unsigned   up_w;
    logic [6:0]    slot_cnt;
    logic [1:0]    pol_cnt;
    logic [7:0]    first_pol;
    logic [31:0]   chan_sp;

    rot_result_t   expected_samples [$];
    int            mismatch_count;
    int            cycle_count;
    bit            calm;
    bit            stale_cache;
    logic [47:0]   last_corr_t;
    int            hold_token;
    int            hold_seen;
    int            hold_left;
    int            stall_left;
    int            stall_roll;

    always #5 clk = ~clk;

    function automatic int q30_to_q16(longint v);
        if (v < 0)
        begin
            v = 0;
        end
        return int'((v + 8192) >> 14);
    endfunction

    function automatic void build_trig_table();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint          ss;
        longint          cs;
        int              c;
        int              s;
        int              q;
        int              j;
        for (int k = 0; k < LUT_N; k++)
        begin
            q = k / QTR;
            j = k % QTR;
            if (j == 0)
            begin
                c = 65536;
                s = 0;
            end
            else
            begin
                x  = (TWO_PI_Q30 * longint'(j) + longint'(LUT_N / 2)) >> DEF_PHASE_LUT_BITS;
                x2 = (x * x) >> 30;
                ts = x;
                ss = longint'(x);
                tc = 64'd1 << 30;
                cs = longint'(tc);
                for (int n = 1; n <= 8; n++)
                begin
                    ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1)
                    begin
                        ss = ss - longint'(ts);
                        cs = cs - longint'(tc);
                    end
                    else
                    begin
                        ss = ss + longint'(ts);
                        cs = cs + longint'(tc);
                    end
                end
                c = q30_to_q16(cs);
                s = q30_to_q16(ss);
            end
            case (q)
                0:       begin cos_t[k] = c;  sin_t[k] = s;  end
                1:       begin cos_t[k] = -s; sin_t[k] = c;  end
                2:       begin cos_t[k] = -c; sin_t[k] = -s; end
                default: begin cos_t[k] = s;  sin_t[k] = -c; end
            endcase
        end
    endfunction

    function automatic int unsigned active_slots();
        if (slot_cnt < 1)
        begin
            return 1;
        end
        if (slot_cnt > NSLOT)
        begin
            return NSLOT;
        end
        return 32'(slot_cnt);
    endfunction

    function automatic int unsigned band_of(logic [3:0] f, logic [7:0] p);
        int unsigned pc;
        pc = (pol_cnt < 1) ? 1 : ((pol_cnt > 2) ? 2 : 32'(pol_cnt));
        return 32'(f) * pc + ((p == first_pol) ? 0 : 1);
    endfunction

    function automatic longint delay_of(int unsigned s, int unsigned a, int unsigned b);
        if (s >= NSLOT || a >= NANT || b >= NBAND)
        begin
            return 0;
        end
        return delay_tab[(s * NANT + a) * NBAND + b];
    endfunction

    function automatic void refresh_weights(logic [47:0] t);
        int unsigned     n;
        int unsigned     up;
        logic [47:0]     t0;
        logic [47:0]     t1;
        longint unsigned num;
        longint unsigned den;
        n = active_slots();
        cached_t = t;
        if (t <= slot_t[0])
        begin
            lo_slot = 0;
            up_slot = 0;
            lo_w = 65536;
            up_w = 0;
            return;
        end
        if (t >= slot_t[n-1])
        begin
            lo_slot = n - 1;
            up_slot = n - 1;
            lo_w = 0;
            up_w = 65536;
            return;
        end
        up = up_slot;
        if (lo_slot < NSLOT && t < slot_t[lo_slot])
        begin
            up = 1;
        end
        if (up < 1)
        begin
            up = 1;
        end
        if (up > n - 1)
        begin
            up = n - 1;
        end
        while (up < n - 1 && t > slot_t[up])
        begin
            up++;
        end
        lo_slot = up - 1;
        up_slot = up;
        t0 = slot_t[lo_slot];
        t1 = slot_t[up_slot];
        if (t1 <= t0)
        begin
            lo_w = 65536;
            up_w = 0;
            return;
        end
        den = t1 - t0;
        num = (t > t0) ? t - t0 : 0;
        if (num > den)
        begin
            num = den;
        end
        up_w = int'((num << 16) / den);
        lo_w = 65536 - up_w;
    endfunction

    function automatic logic signed [15:0] round_sat(longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    function automatic void predict_rotation(item_t it);
        int unsigned     band;
        int unsigned     b1;
        int unsigned     b2;
        int              k;
        longint          d1;
        longint          d2;
        longint          diff;
        longint          re;
        longint          im;
        longint unsigned prod;
        rot_result_t     r;
        case (it.op)
            OP_LOAD_TIME:
            begin
                slot_t[it.slot] = it.tstamp;
            end
            OP_LOAD_DELAY:
            begin
                band = band_of(it.freq, it.pol_a);
                if (band < NBAND)
                begin
                    delay_tab[(it.slot * NANT + it.ant_a) * NBAND + band] = it.delay;
                end
            end
            OP_CORRECT:
            begin
                re = it.re;
                im = it.im;
                if (it.ant_a == it.ant_b && it.pol_a == it.pol_b)
                begin
                    r.re = it.re;
                    r.im = it.im;
                    r.pass = 1'b1;
                end
                else
                begin
                    if (it.tstamp != cached_t)
                    begin
                        refresh_weights(it.tstamp);
                    end
                    b1 = band_of(it.freq, it.pol_a);
                    b2 = band_of(it.freq, it.pol_b);
                    d1 = delay_of(lo_slot, it.ant_a, b1) * longint'(lo_w)
                       + delay_of(up_slot, it.ant_a, b1) * longint'(up_w);
                    d2 = delay_of(lo_slot, it.ant_b, b2) * longint'(lo_w)
                       + delay_of(up_slot, it.ant_b, b2) * longint'(up_w);
                    diff = d2 - d1;
                    prod = {48'd0, it.chan} * {32'd0, chan_sp};
                    prod = prod * 64'(diff);
                    k = int'(((prod + (64'd1 << 45)) >> 46) & 64'(LUT_N - 1));
                    r.re = round_sat(re * cos_t[k] - im * sin_t[k]);
                    r.im = round_sat(re * sin_t[k] + im * cos_t[k]);
                    r.pass = 1'b0;
                end
                expected_samples.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    task automatic send_item(input item_t it);
        int g;
        in_valid    <= 1'b1;
        operation   <= it.op;
        slot        <= it.slot;
        antenna_a   <= it.ant_a;
        antenna_b   <= it.ant_b;
        pol_a       <= it.pol_a;
        pol_b       <= it.pol_b;
        freq_index  <= it.freq;
        time_stamp  <= it.tstamp;
        delay_value <= it.delay;
        channel     <= it.chan;
        sample_re   <= it.re;
        sample_im   <= it.im;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_rotation(it);
        g = pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_SLOT_COUNT:   slot_cnt  = val[6:0];
            REG_POL_COUNT:    pol_cnt   = val[1:0];
            REG_FIRST_POL:    first_pol = val[7:0];
            REG_CHAN_SPACING: chan_sp   = val;
            default:          ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] sc, input logic [31:0] pc,
                            input logic [31:0] fp, input logic [31:0] sp);
        wait_idle();
        write_reg(REG_SLOT_COUNT, sc);
        write_reg(REG_POL_COUNT, pc);
        write_reg(REG_FIRST_POL, fp);
        write_reg(REG_CHAN_SPACING, sp);
        @(posedge clk);
    endtask

    function automatic item_t blank_item(logic [1:0] op);
        item_t it;
        it.op     = op;
        it.slot   = '0;
        it.ant_a  = '0;
        it.ant_b  = 4'd1;
        it.pol_a  = first_pol;
        it.pol_b  = first_pol + 8'd1;
        it.freq   = '0;
        it.tstamp = '0;
        it.delay  = '0;
        it.chan   = 16'd1000;
        it.re     = 16'sd12000;
        it.im     = -16'sd7000;
        return it;
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_pol();
        case ($urandom_range(0, 2))
            0:       return first_pol;
            1:       return first_pol + 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] pick_time();
        int unsigned     n;
        logic [47:0]     lo;
        logic [47:0]     hi;
        longint unsigned span;
        n  = active_slots();
        lo = slot_t[0];
        hi = slot_t[n-1];
        if ($urandom_range(0, 99) < 35)
        begin
            return last_corr_t;
        end
        span = (hi > lo) ? 64'(hi - lo) : 64'd1000;
        case ($urandom_range(0, 9))
            0:       return lo - 48'($urandom_range(0, 500));
            1:       return hi + 48'($urandom_range(0, 500));
            2:       return slot_t[$urandom_range(0, n - 1)];
            default: return lo + 48'({32'd0, $urandom} % (span + 64'd1));
        endcase
    endfunction

    function automatic item_t random_item(bit big);
        item_t it;
        int    r;
        it        = blank_item(OP_CORRECT);
        it.slot   = 6'($urandom);
        it.ant_a  = 4'($urandom);
        it.ant_b  = 4'($urandom);
        it.pol_a  = pick_pol();
        it.pol_b  = pick_pol();
        it.freq   = 4'($urandom);
        it.tstamp = {16'($urandom), 32'($urandom)};
        it.delay  = 32'($urandom);
        it.chan   = 16'($urandom);
        it.re     = pick_sample();
        it.im     = pick_sample();
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            it.ant_a  = 4'($urandom_range(0, 3));
            it.ant_b  = 4'($urandom_range(0, 3));
            it.freq   = big ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 15));
            it.tstamp = pick_time();
            if (!(it.ant_a == it.ant_b && it.pol_a == it.pol_b))
            begin
                if (stale_cache && it.tstamp == cached_t)
                begin
                    it.tstamp = it.tstamp + 48'd1;
                end
                stale_cache = 1'b0;
                last_corr_t = it.tstamp;
            end
        end
        else if (r < 80)
        begin
            it.ant_b = it.ant_a;
            it.pol_b = it.pol_a;
        end
        else if (r < 90)
        begin
            it.op = OP_LOAD_DELAY;
            if ($urandom_range(0, 1) == 0)
            begin
                it.slot  = 6'($urandom_range(0, 7));
                it.ant_a = 4'($urandom_range(0, 3));
            end
        end
        else if (r < 95)
        begin
            it.op     = OP_LOAD_TIME;
            it.tstamp = slot_t[it.slot] + 48'($urandom_range(0, 200)) - 48'd100;
        end
        else
        begin
            it.op = OP_NONE;
        end
        return it;
    endfunction

    // Slot times for every slot, delays for slots 0-7, antennas 0-3, all bands.
    task automatic test_table_fill();
        item_t       it;
        logic [47:0] t;
        t = {16'($urandom_range(1, 16'hFFF0)), 32'($urandom)};
        for (int s = 0; s < NSLOT; s++)
        begin
            it = blank_item(OP_LOAD_TIME);
            it.slot = 6'(s);
            it.tstamp = t;
            send_item(it);
            t = t + 48'($urandom_range(1000, 1 << 20));
        end
        for (int s = 0; s < 8; s++)
        begin
            for (int a = 0; a < 4; a++)
            begin
                for (int b = 0; b < NBAND; b++)
                begin
                    it = blank_item(OP_LOAD_DELAY);
                    it.slot  = 6'(s);
                    it.ant_a = 4'(a);
                    it.freq  = 4'(b / 2);
                    it.pol_a = (b % 2 == 0) ? first_pol : first_pol + 8'd1;
                    it.delay = 32'($urandom);
                    if (s == 0 && a == 0 && b == 0)
                    begin
                        it.delay = 32'sh7FFFFFFF;
                    end
                    if (s == 0 && a == 1 && b == 1)
                    begin
                        it.delay = 32'sh80000000;
                    end
                    send_item(it);
                end
            end
        end
    endtask

    task automatic test_directed();
        item_t it;
        it = blank_item(OP_CORRECT);
        it.tstamp = '0;
        send_item(it);
        set_regs(8, 2, 82, 32'hFFFFFFFF);
        it = blank_item(OP_CORRECT);
        it.ant_a = 4'd15;
        it.ant_b = 4'd15;
        it.pol_a = 8'hFF;
        it.pol_b = 8'hFF;
        it.re = 16'sh8000;
        it.im = 16'sh7FFF;
        send_item(it);
        it.ant_a = 4'd0;
        it.ant_b = 4'd0;
        it.pol_a = 8'h00;
        it.pol_b = 8'h00;
        it.re = 16'sh7FFF;
        it.im = 16'sh8000;
        send_item(it);
        it = blank_item(OP_CORRECT);
        it.tstamp = slot_t[0] - 48'd5;
        send_item(it);
        it.tstamp = slot_t[0];
        it.ant_b = 4'd2;
        send_item(it);
        it.tstamp = slot_t[7] + 48'd9;
        send_item(it);
        it.tstamp = slot_t[7];
        send_item(it);
        it.tstamp = slot_t[4] + (slot_t[5] - slot_t[4]) / 3;
        send_item(it);
        send_item(it);
        it.tstamp = slot_t[1] + 48'd1;
        send_item(it);
        it.chan = 16'hFFFF;
        it.re = 16'sh8000;
        it.im = 16'sh8000;
        send_item(it);
        it.re = 16'sh7FFF;
        it.im = 16'sh7FFF;
        send_item(it);
        it.freq = 4'd15;
        send_item(it);
        it.freq = 4'd3;
        it.ant_a = 4'd3;
        it.ant_b = 4'd3;
        send_item(it);
        it = blank_item(OP_NONE);
        it.slot = '1;
        it.tstamp = '1;
        it.delay = '1;
        it.chan = '1;
        send_item(it);
        it = blank_item(OP_LOAD_DELAY);
        it.freq = 4'd15;
        it.delay = 32'sh12345678;
        send_item(it);
        it.freq = 4'd2;
        it.ant_a = 4'd2;
        it.delay = 32'sh7FFFFFFF;
        send_item(it);
        it = blank_item(OP_LOAD_TIME);
        it.slot = 6'd5;
        it.tstamp = slot_t[5];
        send_item(it);
        last_corr_t = cached_t;
    endtask

    // Two equal slot times bracketing the time give the unit lower weight.
    task automatic test_flat_slots();
        item_t       it;
        logic [47:0] keep;
        keep = slot_t[3];
        it = blank_item(OP_CORRECT);
        it.tstamp = slot_t[2] + 48'd1;
        send_item(it);
        it = blank_item(OP_LOAD_TIME);
        it.slot = 6'd3;
        it.tstamp = slot_t[2];
        send_item(it);
        it = blank_item(OP_CORRECT);
        it.tstamp = slot_t[2];
        send_item(it);
        it = blank_item(OP_LOAD_TIME);
        it.slot = 6'd3;
        it.tstamp = keep;
        send_item(it);
        last_corr_t = cached_t;
    endtask

    task automatic test_random_phases();
        bit big;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_regs(8, 2, 82, $urandom);
                1: set_regs(0, 1, $urandom, $urandom);
                2: set_regs(127, 2, $urandom, 32'hFFFFFFFF);
                3: set_regs(4, 3, 0, 0);
                4: set_regs(64, 3, 255, $urandom);
                5: set_regs(6, 0, 82, $urandom);
                6: set_regs(2, 2, $urandom, 1);
                default: set_regs(8, 1, 82, $urandom);
            endcase
            big = active_slots() > 8;
            calm = (ph == 3);
            if (ph == 5)
            begin
                hold_token = hold_token + 1;
            end
            for (int i = 0; i < 145; i++)
            begin
                send_item(random_item(big));
            end
            if (big)
            begin
                stale_cache = 1'b1;
            end
            calm = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= 500;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (calm)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 60)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 6);
            end
            else if (stall_roll < 95)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                begin
                    $display("Unexpected output item re=%0d im=%0d pass=%0b",
                             out_re, out_im, passed_through);
                end
            end
            else
            begin
                if (out_re !== expected_samples[0].re || out_im !== expected_samples[0].im
                    || passed_through !== expected_samples[0].pass)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                    begin
                        $display("Mismatch: expected re=%0d im=%0d pass=%0b, got re=%0d im=%0d pass=%0b",
                                 expected_samples[0].re, expected_samples[0].im,
                                 expected_samples[0].pass, out_re, out_im, passed_through);
                    end
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = '0;
        slot = '0;
        antenna_a = '0;
        antenna_b = '0;
        pol_a = '0;
        pol_b = '0;
        freq_index = '0;
        time_stamp = '0;
        delay_value = '0;
        channel = '0;
        sample_re = '0;
        sample_im = '0;
        out_stall = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        calm = 1'b0;
        stale_cache = 1'b0;
        hold_token = 0;
        hold_seen = 0;
        hold_left = 0;
        stall_left = 0;
        cached_t = '0;
        last_corr_t = '0;
        lo_slot = 0;
        up_slot = 0;
        lo_w = 0;
        up_w = 0;
        slot_cnt = 7'd1;
        pol_cnt = 2'd2;
        first_pol = 8'd82;
        chan_sp = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            slot_t[i] = '0;
        end
        for (int i = 0; i < NSLOT * NANT * NBAND; i++)
        begin
            delay_tab[i] = 0;
        end
        build_trig_table();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_fill();
        test_directed();
        test_flat_slots();
        test_random_phases();
        wait_idle();
        if (mismatch_count == 0 && expected_samples.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
